// ----- hdl/running_fraction_sum_reduce_macros.svh -----
// assertion helpers used by the running_fraction_sum_reduce module
`ifndef RUNNING_FRACTION_SUM_REDUCE_MACROS_SVH
`define RUNNING_FRACTION_SUM_REDUCE_MACROS_SVH

// implication check on the rising clock edge, held off during reset
`define RFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define RFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rfs_pkg.sv -----
// ----------------------------------------------------------------------------
// rfs_pkg
// types and constants for the running fraction sum
// ----------------------------------------------------------------------------
`default_nettype none
package rfs_pkg;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,        // euclid remainder loop
    ST_DIV_N,      // n / g
    ST_DIV_D,      // d / g
    ST_CHECK,
    ST_MUL0,       // an * d
    ST_MUL1,       // n * ad
    ST_MUL2,       // ad * d
    ST_ADD,
    ST_COMMIT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/rfs_if.sv -----
// ----------------------------------------------------------------------------
// rfs_in_if / rfs_out_if
// valid/ready channels of the running fraction sum
// ----------------------------------------------------------------------------
`default_nettype none
interface rfs_in_if import rfs_pkg::*; ();
  logic valid;
  logic ready;
  logic [FieldWidth-1:0] numerator;
  logic [FieldWidth-1:0] denominator;
  logic start_new_sum;
  modport source (output valid, numerator, denominator, start_new_sum, input ready);
  modport sink (input valid, numerator, denominator, start_new_sum, output ready);
endinterface

interface rfs_out_if import rfs_pkg::*; ();
  logic valid;
  logic ready;
  logic [FieldWidth-1:0] sum_numerator;
  logic [FieldWidth-1:0] sum_denominator;
  logic [StatusWidth-1:0] status;
  modport source (output valid, sum_numerator, sum_denominator, status, input ready);
  modport sink (input valid, sum_numerator, sum_denominator, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/running_fraction_sum_reduce.sv -----
// ----------------------------------------------------------------------------
// running_fraction_sum_reduce
// keeps a reduced running sum of signed fractions
// ----------------------------------------------------------------------------
// usage:
//   in  : numerator, denominator, start_new_sum under valid/ready
//   out : sum_numerator, sum_denominator, status under valid/ready, one per item
// each item is handled alone by a sequencer around two shared units: a
// restoring divider of 2*VALUE_WIDTH bits (one quotient bit per cycle) used for
// every euclid remainder and both exact divisions, and one multiplier used
// three times: for the two cross products and the product of the denominators.
// an item takes one reduction for the input and, when it is added to a kept
// sum, a second one for the sum.
// in_ready is high only in idle, and the next item is taken once the result
// has been handed over; a stalled receiver holds the block in its output
// state with the result steady.
// reset (synchronous, rst_n low) gives the sum 0/1 with no sum yet.
`default_nettype none
`include "running_fraction_sum_reduce_macros.svh"
module running_fraction_sum_reduce import rfs_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rfs_in_if.sink    in_ch,
  rfs_out_if.source out_ch
);
  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned DW = 2 * VALUE_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [DW-1:0] Half = {{(DW-1){1'b0}}, 1'b1} << (W - 1);

  state_t state_r, state_nxt;

  // magnitudes and signs of the working terms
  logic a_neg_r, a_neg_nxt;                    // sign of euclid dividend
  logic [DW-1:0] b_r, b_nxt;                   // euclid divisor
  logic b_neg_r, b_neg_nxt;
  logic [DW-1:0] n_r, n_nxt, d_r, d_nxt;       // fraction being reduced
  logic n_neg_r, n_neg_nxt, d_neg_r, d_neg_nxt;
  logic [DW-1:0] p_r, p_nxt;                   // an*d
  logic p_neg_r, p_neg_nxt;
  logic [DW-1:0] q_r, q_nxt;                   // n*ad
  logic q_neg_r, q_neg_nxt;
  logic sum_phase_r, sum_phase_nxt;            // second reduction in progress
  logic start_r, start_nxt;

  logic [W-1:0] acc_n_r, acc_n_nxt, acc_d_r, acc_d_nxt;
  logic acc_valid_r, acc_valid_nxt;
  logic [StatusWidth-1:0] status_r, status_nxt;

  // shared divider
  logic [DW-1:0] dv_rem_r, dv_rem_nxt, dv_quo_r, dv_quo_nxt, dv_num_r, dv_num_nxt;
  logic [CW-1:0] dv_cnt_r, dv_cnt_nxt;
  logic dv_busy_r, dv_busy_nxt;
  logic [DW:0] dv_trial;
  logic [DW-1:0] dv_shift;

  // shared multiplier
  logic [W-1:0] mul_x, mul_y;
  logic [DW-1:0] mul_p;

  logic [W-1:0] in_n, in_d;
  logic [W-1:0] in_n_mag, in_d_mag;
  logic in_n_neg, in_d_neg;
  logic out_stall;

  assign in_n = in_ch.numerator[W-1:0];
  assign in_d = in_ch.denominator[W-1:0];
  assign in_n_neg = in_n[W-1];
  assign in_d_neg = in_d[W-1];
  assign in_n_mag = in_n_neg ? (~in_n + 1'b1) : in_n;
  assign in_d_mag = in_d_neg ? (~in_d + 1'b1) : in_d;

  assign mul_p = DW'(mul_x) * DW'(mul_y);
  assign dv_shift = {dv_rem_r[DW-2:0], dv_num_r[DW-1]};
  assign dv_trial = {1'b0, dv_shift} - {1'b0, b_r};

  function automatic logic fits(input logic neg, input logic [DW-1:0] mag);
    fits = neg ? (mag <= Half) : (mag < Half);
  endfunction

  function automatic logic [W-1:0] enc(input logic neg, input logic [DW-1:0] mag);
    logic [DW-1:0] v;
    v = neg ? (~mag + 1'b1) : mag;
    enc = v[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_n_r <= '0;
      acc_d_r <= W'(1);
      acc_valid_r <= 1'b0;
      dv_busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_n_r <= acc_n_nxt;
      acc_d_r <= acc_d_nxt;
      acc_valid_r <= acc_valid_nxt;
      dv_busy_r <= dv_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r <= a_neg_nxt;
    b_r <= b_nxt; b_neg_r <= b_neg_nxt;
    n_r <= n_nxt; n_neg_r <= n_neg_nxt;
    d_r <= d_nxt; d_neg_r <= d_neg_nxt;
    p_r <= p_nxt; p_neg_r <= p_neg_nxt;
    q_r <= q_nxt; q_neg_r <= q_neg_nxt;
    sum_phase_r <= sum_phase_nxt;
    start_r <= start_nxt;
    status_r <= status_nxt;
    dv_rem_r <= dv_rem_nxt;
    dv_quo_r <= dv_quo_nxt;
    dv_num_r <= dv_num_nxt;
    dv_cnt_r <= dv_cnt_nxt;
  end

  always_comb begin
    logic dv_done;
    logic [DW-1:0] rem_f;
    logic [DW-1:0] sm;
    logic sneg;
    state_nxt = state_r;
    a_neg_nxt = a_neg_r;
    b_nxt = b_r; b_neg_nxt = b_neg_r;
    n_nxt = n_r; n_neg_nxt = n_neg_r;
    d_nxt = d_r; d_neg_nxt = d_neg_r;
    p_nxt = p_r; p_neg_nxt = p_neg_r;
    q_nxt = q_r; q_neg_nxt = q_neg_r;
    sum_phase_nxt = sum_phase_r;
    start_nxt = start_r;
    acc_n_nxt = acc_n_r;
    acc_d_nxt = acc_d_r;
    acc_valid_nxt = acc_valid_r;
    status_nxt = status_r;
    dv_rem_nxt = dv_rem_r;
    dv_quo_nxt = dv_quo_r;
    dv_num_nxt = dv_num_r;
    dv_cnt_nxt = dv_cnt_r;
    dv_busy_nxt = dv_busy_r;
    mul_x = '0;
    mul_y = '0;
    sm = '0;
    sneg = 1'b0;
    dv_done = 1'b0;
    rem_f = dv_rem_r;
    in_ch.ready = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);

    // one quotient bit per cycle; b_r is the divisor in every use
    if (dv_busy_r) begin
      if (dv_cnt_r == '0) begin
        dv_busy_nxt = 1'b0;
        dv_done = 1'b1;
      end else begin
        dv_num_nxt = {dv_num_r[DW-2:0], 1'b0};
        if (!dv_trial[DW]) begin
          dv_rem_nxt = dv_trial[DW-1:0];
          dv_quo_nxt = {dv_quo_r[DW-2:0], 1'b1};
        end else begin
          dv_rem_nxt = dv_shift;
          dv_quo_nxt = {dv_quo_r[DW-2:0], 1'b0};
        end
        dv_cnt_nxt = dv_cnt_r - 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          start_nxt = in_ch.start_new_sum;
          sum_phase_nxt = 1'b0;
          n_neg_nxt = in_n_neg;
          n_nxt = {{W{1'b0}}, in_n_mag};
          d_neg_nxt = in_d_neg;
          d_nxt = {{W{1'b0}}, in_d_mag};
          if (in_d == '0) begin
            status_nxt = STATUS_ZERO_DEN;
            state_nxt = ST_OUT;
          end else begin
            status_nxt = STATUS_OK;
            a_neg_nxt = in_n_neg;
            b_nxt = {{W{1'b0}}, in_d_mag};
            b_neg_nxt = in_d_neg;
            dv_num_nxt = {{W{1'b0}}, in_n_mag};
            dv_rem_nxt = '0;
            dv_quo_nxt = '0;
            dv_cnt_nxt = CW'(DW);
            dv_busy_nxt = 1'b1;
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (dv_done) begin
          rem_f = dv_rem_r;
          if (rem_f == '0) begin
            // b is the gcd; divide n by it
            dv_num_nxt = n_r;
            dv_rem_nxt = '0;
            dv_quo_nxt = '0;
            dv_cnt_nxt = CW'(DW);
            dv_busy_nxt = 1'b1;
            state_nxt = ST_DIV_N;
          end else begin
            a_neg_nxt = b_neg_r;
            b_nxt = rem_f; b_neg_nxt = a_neg_r;
            dv_num_nxt = b_r;
            dv_rem_nxt = '0;
            dv_quo_nxt = '0;
            dv_cnt_nxt = CW'(DW);
            dv_busy_nxt = 1'b1;
          end
        end
      end
      ST_DIV_N: begin
        if (dv_done) begin
          n_nxt = dv_quo_r;
          n_neg_nxt = (n_neg_r != b_neg_r) && (dv_quo_r != '0);
          dv_num_nxt = d_r;
          dv_rem_nxt = '0;
          dv_quo_nxt = '0;
          dv_cnt_nxt = CW'(DW);
          dv_busy_nxt = 1'b1;
          state_nxt = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (dv_done) begin
          d_nxt = dv_quo_r;
          d_neg_nxt = (d_neg_r != b_neg_r) && (dv_quo_r != '0);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_OUT;
        if (!fits(n_neg_r, n_r) || !fits(d_neg_r, d_r)) begin
          status_nxt = STATUS_OVERFLOW;
        end else if (sum_phase_r) begin
          acc_n_nxt = enc(n_neg_r, n_r);
          acc_d_nxt = enc(d_neg_r, d_r);
        end else if (start_r || !acc_valid_r) begin
          acc_n_nxt = enc(n_neg_r, n_r);
          acc_d_nxt = enc(d_neg_r, d_r);
          acc_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        mul_x = acc_n_r[W-1] ? (~acc_n_r + 1'b1) : acc_n_r;
        mul_y = d_r[W-1:0];
        p_nxt = mul_p;
        p_neg_nxt = (acc_n_r[W-1] != d_neg_r) && (mul_p != '0);
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        mul_x = n_r[W-1:0];
        mul_y = acc_d_r[W-1] ? (~acc_d_r + 1'b1) : acc_d_r;
        q_nxt = mul_p;
        q_neg_nxt = (n_neg_r != acc_d_r[W-1]) && (mul_p != '0);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        mul_x = acc_d_r[W-1] ? (~acc_d_r + 1'b1) : acc_d_r;
        mul_y = d_r[W-1:0];
        d_nxt = mul_p;
        d_neg_nxt = (acc_d_r[W-1] != d_neg_r) && (mul_p != '0);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (p_neg_r == q_neg_r) begin
          sm = p_r + q_r; sneg = p_neg_r;
        end else if (p_r >= q_r) begin
          sm = p_r - q_r; sneg = p_neg_r;
        end else begin
          sm = q_r - p_r; sneg = q_neg_r;
        end
        if (sm == '0) sneg = 1'b0;
        n_nxt = sm; n_neg_nxt = sneg;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // second reduction over the double-width sum
        sum_phase_nxt = 1'b1;
        a_neg_nxt = n_neg_r;
        b_nxt = d_r; b_neg_nxt = d_neg_r;
        dv_num_nxt = n_r;
        dv_rem_nxt = '0;
        dv_quo_nxt = '0;
        dv_cnt_nxt = CW'(DW);
        dv_busy_nxt = 1'b1;
        state_nxt = ST_GCD;
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.sum_numerator = FieldWidth'($signed(acc_n_r));
  assign out_ch.sum_denominator = FieldWidth'($signed(acc_d_r));
  assign out_ch.status = status_r;

  assign out_stall = out_ch.valid && !out_ch.ready;

  `RFS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, !out_ch.valid, "result still pending")
  `RFS_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_stall, out_ch.valid, "valid dropped")
  `RFS_ASSERT_NEXT(a_hold_sum, clk, rst_n, out_stall, $stable({acc_n_r, acc_d_r}), "sum moved")
  `RFS_ASSERT_IMP(a_den_nonzero, clk, rst_n, acc_valid_r, acc_d_r != '0, "zero kept denominator")
  `RFS_ASSERT_IMP(a_div_nonzero, clk, rst_n, dv_busy_r, b_r != '0, "divide by zero")
endmodule
`default_nettype wire

// ----- test/running_fraction_sum_reduce_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_fraction_sum_reduce_tb
// drives signed fractions into the running sum and checks every reduced sum
// ----------------------------------------------------------------------------
// a scoreboard object keeps its own running sum in sign/magnitude form,
// reduces with a truncating euclid loop and queues the sum and status
// predicted for each accepted item. results are checked in order as they
// leave the block. the sender works in bursts with gaps, the receiver
// stalls on a changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  bit        neg;
  bit [63:0] mag;
} frac_term_t;

typedef struct {
  bit [31:0]        num;
  bit [31:0]        den;
  rfs_pkg::status_t st;
} sum_result_t;

class fraction_sum_scoreboard;
  localparam int VW = rfs_pkg::DefValueWidth;

  bit [31:0]   kept_num;
  bit [31:0]   kept_den;
  bit          have_sum;
  sum_result_t sums_due[$];
  int          mismatches;
  int          checked;
  int          status_seen[3];

  function new();
    kept_num = 0;
    kept_den = 1;
    have_sum = 0;
    mismatches = 0;
    checked = 0;
    status_seen = '{0, 0, 0};
  endfunction

  function frac_term_t unpack_term(bit [31:0] v);
    frac_term_t t;
    bit [63:0] mask;
    bit [63:0] w;
    mask = (64'd1 << VW) - 1;
    w = {32'd0, v} & mask;
    t.neg = w[VW-1];
    t.mag = t.neg ? ((~w + 1) & mask) : w;
    return t;
  endfunction

  function bit [31:0] pack_term(frac_term_t t);
    bit [63:0] w;
    w = t.neg ? (64'd0 - t.mag) : t.mag;
    return w[31:0];
  endfunction

  function bit in_range(frac_term_t t);
    bit [63:0] half;
    half = 64'd1 << (VW - 1);
    return t.neg ? (t.mag <= half) : (t.mag < half);
  endfunction

  // remainder takes the sign of the dividend
  function frac_term_t trunc_rem(frac_term_t a, frac_term_t b);
    frac_term_t r;
    r.mag = a.mag % b.mag;
    r.neg = a.neg && r.mag != 0;
    return r;
  endfunction

  function void reduce_pair(ref frac_term_t n, ref frac_term_t d);
    frac_term_t a, b, r;
    a = n;
    b = d;
    r = trunc_rem(a, b);
    while (r.mag != 0) begin
      a = b;
      b = r;
      r = trunc_rem(a, b);
    end
    n.mag = n.mag / b.mag;
    n.neg = (n.neg != b.neg) && n.mag != 0;
    d.mag = d.mag / b.mag;
    d.neg = (d.neg != b.neg) && d.mag != 0;
  endfunction

  function frac_term_t times(frac_term_t a, frac_term_t b);
    frac_term_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && r.mag != 0;
    return r;
  endfunction

  function frac_term_t plus(frac_term_t a, frac_term_t b);
    frac_term_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function void note_fraction(bit [31:0] num, bit [31:0] den, bit start);
    frac_term_t n, d, an, ad, sn, sd;
    sum_result_t e;
    n = unpack_term(num);
    d = unpack_term(den);
    e.st = rfs_pkg::STATUS_OK;
    if (d.mag == 0) begin
      e.st = rfs_pkg::STATUS_ZERO_DEN;
    end else begin
      reduce_pair(n, d);
      if (!in_range(n) || !in_range(d)) begin
        e.st = rfs_pkg::STATUS_OVERFLOW;
      end else if (start || !have_sum) begin
        kept_num = pack_term(n);
        kept_den = pack_term(d);
        have_sum = 1;
      end else begin
        an = unpack_term(kept_num);
        ad = unpack_term(kept_den);
        sn = plus(times(an, d), times(n, ad));
        sd = times(ad, d);
        reduce_pair(sn, sd);
        if (!in_range(sn) || !in_range(sd)) begin
          e.st = rfs_pkg::STATUS_OVERFLOW;
        end else begin
          kept_num = pack_term(sn);
          kept_den = pack_term(sd);
        end
      end
    end
    e.num = kept_num;
    e.den = kept_den;
    sums_due.push_back(e);
  endfunction

  function void check_sum(bit [31:0] num, bit [31:0] den, bit [1:0] st);
    sum_result_t e;
    if (sums_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %0d/%0d status %0d", $signed(num), $signed(den), st);
      return;
    end
    e = sums_due.pop_front();
    checked++;
    if (e.st <= rfs_pkg::STATUS_OVERFLOW) status_seen[e.st]++;
    if (num !== e.num || den !== e.den || st !== e.st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                 checked, $signed(e.num), $signed(e.den), e.st,
                 $signed(num), $signed(den), st);
    end
  endfunction
endclass

module running_fraction_sum_reduce_tb;
  import rfs_pkg::*;

  localparam int RandomItems = 430;

  logic clk;
  logic rst_n;
  int   stall_mode;
  fraction_sum_scoreboard sums;

  rfs_in_if  in_ch();
  rfs_out_if out_ch();

  running_fraction_sum_reduce u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #200ms;
    $display("running_fraction_sum_reduce test failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic push_item(bit [31:0] num, bit [31:0] den, bit start);
    in_ch.numerator = num;
    in_ch.denominator = den;
    in_ch.start_new_sum = start;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    sums.note_fraction(num, den, start);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid = 0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 0;
    while (sums.sums_due.size() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_term(int kind);
    case (kind)
      0, 1, 2, 3: pick_term = 32'($urandom_range(0, 60) - 30);
      4, 5:       pick_term = 32'($urandom_range(0, 65536) - 32768);
      6, 7:       pick_term = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: pick_term = 32'h8000_0000;
          1: pick_term = 32'h7fff_ffff;
          2: pick_term = 32'hffff_ffff;
          3: pick_term = 32'd0;
          4: pick_term = 32'd1;
          default: pick_term = 32'h8000_0000 | $urandom_range(0, 7);
        endcase
      end
    endcase
  endfunction

  // receiver: sample at the rising edge, change ready at the falling edge
  initial begin
    int cnt;
    cnt = 0;
    stall_mode = 0;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sums.check_sum(out_ch.sum_numerator, out_ch.sum_denominator, out_ch.status);
      @(negedge clk);
      cnt++;
      if (cnt % 3000 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready = 1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        2: out_ch.ready = ((cnt / 50) % 2 == 0);
        default: out_ch.ready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    int kind, burst;
    bit [31:0] n, d;
    sums = new();
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.numerator = 0;
    in_ch.denominator = 0;
    in_ch.start_new_sum = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // zero denominator before any sum, then first item without start
    push_item(32'd5, 32'd0, 1'b0);
    push_item(32'd6, 32'd4, 1'b0);
    push_item(32'd0, 32'd7, 1'b0);
    push_item(32'd0, 32'hffff_fff9, 1'b1);
    push_item(32'd3, 32'hffff_fffa, 1'b1);
    push_item(32'hffff_fffe, 32'hffff_fffc, 1'b0);
    pause_sender(3);
    // most negative over -1 does not fit
    push_item(32'h8000_0000, 32'hffff_ffff, 1'b0);
    push_item(32'h8000_0000, 32'd1, 1'b1);
    push_item(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    push_item(32'd1, 32'h7fff_ffff, 1'b1);
    // sum denominator too wide
    push_item(32'd1, 32'h7fff_fffe, 1'b0);
    push_item(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    push_item(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_item(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    push_item(32'h0, 32'h0, 1'b0);
    push_item(32'h1234_5678, 32'h9abc_def0, 1'b1);
    push_item(32'h7fff_ffff, 32'd2, 1'b0);
    push_item(32'h7fff_ffff, 32'd1, 1'b1);
    push_item(32'h7fff_ffff, 32'd1, 1'b0);
    drain_results();

    for (int i = 0; i < RandomItems; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && i < RandomItems; j++, i++) begin
        kind = $urandom_range(0, 9);
        n = pick_term(kind);
        d = pick_term(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : kind);
        push_item(n, d, $urandom_range(0, 7) == 0);
      end
      if (i % 97 < burst) drain_results();
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end

    drain_results();
    repeat (200) @(posedge clk);
    $display("checked %0d sums: %0d ok, %0d zero denominator, %0d overflow",
             sums.checked, sums.status_seen[0], sums.status_seen[1], sums.status_seen[2]);
    $display("mismatches: %0d", sums.mismatches);
    if (sums.mismatches == 0 && sums.sums_due.size() == 0) begin
      $display("running_fraction_sum_reduce test passed");
    end else begin
      $display("running_fraction_sum_reduce test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
